### rtl/skf_pkg.sv
// Shared types, codes and the scancode translation table for the keyboard FIFO.
// Used by skf_ctrl and scancode_keyboard_fifo; it depends on nothing else.
`timescale 1ns / 1ps

package skf_pkg;

   localparam int OPCODE_W = 2;
   localparam int BYTE_W   = 8;
   localparam int FILL_W   = 9;

   localparam logic [OPCODE_W-1:0] OP_EVENT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [BYTE_W-1:0] VEC_DOUBLE_FAULT = 8'd8;
   localparam logic [BYTE_W-1:0] VEC_GP_FAULT     = 8'd13;
   localparam logic [BYTE_W-1:0] VEC_PAGE_FAULT   = 8'd14;
   localparam logic [BYTE_W-1:0] VEC_IRQ_BASE     = 8'd32;
   localparam logic [BYTE_W-1:0] VEC_KEYBOARD     = 8'd33;
   localparam logic [BYTE_W-1:0] VEC_SLAVE_BASE   = 8'd40;
   localparam logic [BYTE_W-1:0] VEC_IRQ_LAST     = 8'd47;

   localparam logic [BYTE_W-1:0] CHAR_NONE = 8'h00;

   typedef struct packed {
      logic eoi_master;
      logic eoi_slave;
      logic exception_flag;
      logic halt_request;
      logic char_stored;
      logic pop;
   } flags_type;

   // Scancode set 1 make codes to ASCII. Break codes and codes of 64 and
   // above map to no character.
   function automatic logic [BYTE_W-1:0] translate(input logic [BYTE_W-1:0] code);
      logic [BYTE_W-1:0] ch;
      ch = CHAR_NONE;
      if (code[7:6] == 2'b00) begin
         unique case (code[5:0])
            6'h0E: ch = 8'h08;
            6'h10: ch = 8'h71;
            6'h11: ch = 8'h77;
            6'h12: ch = 8'h65;
            6'h13: ch = 8'h72;
            6'h14: ch = 8'h74;
            6'h15: ch = 8'h79;
            6'h16: ch = 8'h75;
            6'h17: ch = 8'h69;
            6'h18: ch = 8'h6F;
            6'h19: ch = 8'h70;
            6'h1C: ch = 8'h0A;
            6'h1E: ch = 8'h61;
            6'h1F: ch = 8'h73;
            6'h20: ch = 8'h64;
            6'h21: ch = 8'h66;
            6'h22: ch = 8'h67;
            6'h23: ch = 8'h68;
            6'h24: ch = 8'h6A;
            6'h25: ch = 8'h6B;
            6'h26: ch = 8'h6C;
            6'h2C: ch = 8'h7A;
            6'h2D: ch = 8'h78;
            6'h2E: ch = 8'h63;
            6'h2F: ch = 8'h76;
            6'h30: ch = 8'h62;
            6'h31: ch = 8'h6E;
            6'h32: ch = 8'h6D;
            6'h39: ch = 8'h20;
            default: ch = CHAR_NONE;
         endcase
      end
      return ch;
   endfunction

endpackage

### rtl/scancode_keyboard_fifo.sv
// Keyboard interrupt front end with a character FIFO. The result of an accepted
// item is registered and valid in the next cycle. Throughput: one item per cycle
// while the result side takes each result, set by the single result register and
// the registered read port of the character memory. Reset clears the pointers, the
// fill count and the result valid; the character memory is not cleared.
// Depends on skf_pkg, skf_ctrl and skf_store.
`timescale 1ns / 1ps

module scancode_keyboard_fifo #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [skf_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [skf_pkg::BYTE_W-1:0]   req_vector_number,
   input  logic [skf_pkg::BYTE_W-1:0]   req_scan_code,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [skf_pkg::BYTE_W-1:0]   rsp_read_char,
   output logic                         rsp_eoi_master,
   output logic                         rsp_eoi_slave,
   output logic                         rsp_exception_flag,
   output logic                         rsp_halt_request,
   output logic                         rsp_char_stored,
   output logic [skf_pkg::FILL_W-1:0]   rsp_fill_level,
   output logic                         rsp_has_data
);

   import skf_pkg::*;

   localparam int ADDR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

   logic              req_fire;
   flags_type         flags;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;
   logic [CNT_W-1:0]  count_cur, count_next;

   logic              rsp_valid_ff, rsp_valid_in;
   flags_type         flags_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              has_data_ff;

   // The next item enters as soon as the waiting result is taken.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   skf_ctrl #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .fire          (req_fire),
      .opcode        (req_opcode),
      .vector_number (req_vector_number),
      .scan_code     (req_scan_code),
      .flags         (flags),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .count_cur     (count_cur),
      .count_next    (count_next)
   );

   skf_store #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         flags_ff    <= flags;
         fill_ff     <= FILL_W'(count_next);
         has_data_ff <= (count_next != '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_char      = flags_ff.pop ? rd_data : CHAR_NONE;
   assign rsp_eoi_master     = flags_ff.eoi_master;
   assign rsp_eoi_slave      = flags_ff.eoi_slave;
   assign rsp_exception_flag = flags_ff.exception_flag;
   assign rsp_halt_request   = flags_ff.halt_request;
   assign rsp_char_stored    = flags_ff.char_stored;
   assign rsp_fill_level     = fill_ff;
   assign rsp_has_data       = has_data_ff;

`ifndef SYNTHESIS
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_opcode == OP_CLEAR) |=> rsp_valid && !rsp_has_data)
      else $error("clear did not empty the FIFO");

   a_has_data_tracks_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_data == (count_cur != '0)))
      else $error("reported has_data disagrees with the held count");

   a_empty_read_zero: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_opcode == OP_READ) && (count_cur == '0) |=>
      rsp_read_char == CHAR_NONE)
      else $error("read of an empty FIFO returned a character");

   a_store_on_master_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_stored |-> rsp_eoi_master && !rsp_eoi_slave)
      else $error("character stored outside the keyboard vector");
`endif

endmodule

### rtl/skf_store.sv
// Character storage for the keyboard FIFO: one write port, one registered read port.
// Stand-alone; addresses and enables come from skf_ctrl.
`timescale 1ns / 1ps

module skf_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read data only moves on a pop, so it holds while a result is stalled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/skf_ctrl.sv
// Item decode and FIFO bookkeeping: pointers, fill count and the result flags.
// Depends on skf_pkg for opcodes, vector codes and the translation table.
`timescale 1ns / 1ps

module skf_ctrl #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int CNT_W  = 9
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic [skf_pkg::OPCODE_W-1:0]   opcode,
   input  logic [skf_pkg::BYTE_W-1:0]     vector_number,
   input  logic [skf_pkg::BYTE_W-1:0]     scan_code,
   output skf_pkg::flags_type             flags,
   output logic                           wr_en,
   output logic [ADDR_W-1:0]              wr_addr,
   output logic [skf_pkg::BYTE_W-1:0]     wr_data,
   output logic                           rd_en,
   output logic [ADDR_W-1:0]              rd_addr,
   output logic [CNT_W-1:0]               count_cur,
   output logic [CNT_W-1:0]               count_next
);

   import skf_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] ch;
   logic              clear;

   assign ch = translate(scan_code);

   always_comb begin
      flags = '0;
      clear = 1'b0;
      unique case (opcode)
         OP_EVENT: begin
            if (vector_number < VEC_IRQ_BASE) begin
               flags.exception_flag = 1'b1;
               flags.halt_request   = (vector_number == VEC_DOUBLE_FAULT) ||
                                      (vector_number == VEC_GP_FAULT) ||
                                      (vector_number == VEC_PAGE_FAULT);
            end else if (vector_number <= VEC_IRQ_LAST) begin
               flags.eoi_master  = 1'b1;
               flags.eoi_slave   = (vector_number >= VEC_SLAVE_BASE);
               flags.char_stored = (vector_number == VEC_KEYBOARD) &&
                                   (ch != CHAR_NONE) && (count_ff < FULL_CNT);
            end
         end
         OP_READ:  flags.pop = (count_ff != '0);
         OP_CLEAR: clear = 1'b1;
         default:  flags = '0;
      endcase
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (fire) begin
         if (clear) begin
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            count_in  = '0;
         end else if (flags.char_stored) begin
            wr_ptr_in = (wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + 1'b1;
            count_in  = count_ff + 1'b1;
         end else if (flags.pop) begin
            rd_ptr_in = (rd_ptr_ff == LAST_ADDR) ? '0 : rd_ptr_ff + 1'b1;
            count_in  = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign wr_en      = fire && flags.char_stored;
   assign wr_addr    = wr_ptr_ff;
   assign wr_data    = ch;
   assign rd_en      = fire && flags.pop;
   assign rd_addr    = rd_ptr_ff;
   assign count_cur  = count_ff;
   assign count_next = count_in;

endmodule
